[src/karpa_pkg.sv]
`timescale 1ns / 1ps

package karpa_pkg;

	localparam int TIME_WIDTH_DEFAULT = 32;
	localparam int NUM_BUTTONS        = 6;
	localparam int NUM_VALUES         = 3;
	localparam int VALUE_WIDTH        = 10;
	localparam int MS_WIDTH           = 16;
	localparam int STAMP_WIDTH        = 32;
	localparam int CFG_DATA_WIDTH     = 16;

	localparam logic [MS_WIDTH-1:0]    DEAD_TIME_RESET      = 16'd50;
	localparam logic [MS_WIDTH-1:0]    REPEAT_START_RESET   = 16'd1000;
	localparam logic [MS_WIDTH-1:0]    REPEAT_INTERVAL_RESET = 16'd250;
	localparam logic [VALUE_WIDTH-1:0] TEMP_UPPER_RESET     = 10'd300;
	localparam logic [VALUE_WIDTH-1:0] HOLD_LOWER_RESET     = 10'd1;
	localparam logic [VALUE_WIDTH-1:0] HOLD_UPPER_RESET     = 10'd999;
	localparam logic [VALUE_WIDTH-1:0] HOLD_VALUE_RESET     = 10'd1;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_DEAD_TIME       = 3'd0,
		REG_REPEAT_START    = 3'd1,
		REG_REPEAT_INTERVAL = 3'd2,
		REG_TEMP_UPPER      = 3'd3,
		REG_HOLD_LOWER      = 3'd4,
		REG_HOLD_UPPER      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                   action;
		logic [STAMP_WIDTH-1:0] now_ms;
		logic [NUM_BUTTONS-1:0] button_levels;
		logic                   change_allowed;
		logic [VALUE_WIDTH-1:0] load_temp_one;
		logic [VALUE_WIDTH-1:0] load_temp_two;
		logic [VALUE_WIDTH-1:0] load_hold_minutes;
	} poll_item_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] target_temp_one;
		logic [VALUE_WIDTH-1:0] target_temp_two;
		logic [VALUE_WIDTH-1:0] hold_minutes_value;
		logic [NUM_BUTTONS-1:0] repeat_mask;
	} result_item_t;

endpackage

[src/karpa_if.sv]
`timescale 1ns / 1ps

interface karpa_poll_if;
	import karpa_pkg::*;

	logic       valid;
	logic       ready;
	poll_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface karpa_result_if;
	import karpa_pkg::*;

	logic         valid;
	logic         ready;
	result_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface karpa_cfg_if;
	import karpa_pkg::*;

	logic                      valid;
	logic                      ready;
	cfg_reg_t                  index;
	logic [CFG_DATA_WIDTH-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[src/key_auto_repeat_param_adjust.sv]
`timescale 1ns / 1ps

// Key hold auto repeat with parameter adjustment. Each poll item carries a
// millisecond stamp and six button levels; buttons 0/1 raise/lower the first
// target temperature, 2/3 the second, 4/5 the hold minutes. A held button
// steps once after the dead time, once more when the repeat start is reached,
// then once per repeat interval. One item is taken every clock cycle while the
// result side keeps up; the result passes through the input register, then the
// result register, and is offered once it sits in the result register. The
// per-button wrapping time subtract and compare between those two registers,
// followed by the step sum and clamp, sets the cycle time.
// A full result register does not stop the next item being taken into a free
// input register; once both are full the poll side is held off until the
// result is taken. Configuration writes are taken every cycle and should only
// be issued while the block is idle.

module key_auto_repeat_param_adjust #(
	parameter int TIME_WIDTH = karpa_pkg::TIME_WIDTH_DEFAULT
) (
	input logic               clk,
	input logic               arst_n,
	karpa_poll_if.sink        poll,
	karpa_result_if.source    result,
	karpa_cfg_if.sink         cfg
);
	import karpa_pkg::*;

	localparam int TW = TIME_WIDTH;

	typedef logic [TW-1:0] stamp_t;

	// configuration registers
	logic [MS_WIDTH-1:0]    dead_q;
	logic [MS_WIDTH-1:0]    rstart_q;
	logic [MS_WIDTH-1:0]    rint_q;
	logic [VALUE_WIDTH-1:0] temp_hi_q;
	logic [VALUE_WIDTH-1:0] hold_lo_q;
	logic [VALUE_WIDTH-1:0] hold_hi_q;

	// button tracking state
	logic [NUM_BUTTONS-1:0] prior_q;
	logic [NUM_BUTTONS-1:0] first_q;
	logic [NUM_BUTTONS-1:0] rep_q;
	stamp_t                 press_q [NUM_BUTTONS];
	stamp_t                 last_q  [NUM_BUTTONS];
	logic [VALUE_WIDTH-1:0] temp1_q;
	logic [VALUE_WIDTH-1:0] temp2_q;
	logic [VALUE_WIDTH-1:0] hold_q;

	// pipeline
	logic         valid_s1;
	poll_item_t   item_s1;
	logic         valid_s2;
	result_item_t res_s2;

	logic s2_free;
	logic advance;

	// next state
	logic [NUM_BUTTONS-1:0] first_nxt;
	logic [NUM_BUTTONS-1:0] rep_nxt;
	stamp_t                 press_nxt [NUM_BUTTONS];
	stamp_t                 last_nxt  [NUM_BUTTONS];
	stamp_t                 held      [NUM_BUTTONS];
	stamp_t                 since     [NUM_BUTTONS];
	logic [1:0]             steps     [NUM_BUTTONS];
	logic signed [2:0]      delta     [NUM_VALUES];
	logic [63:0]            now_wide;
	stamp_t                 now;
	logic signed [11:0]     sum1;
	logic signed [11:0]     sum2;
	logic signed [11:0]     sum3;
	logic [VALUE_WIDTH-1:0] temp1_nxt;
	logic [VALUE_WIDTH-1:0] temp2_nxt;
	logic [VALUE_WIDTH-1:0] hold_nxt;

	function automatic logic [VALUE_WIDTH-1:0] clamp_val(
		input logic signed [11:0]     v,
		input logic [VALUE_WIDTH-1:0] lo,
		input logic [VALUE_WIDTH-1:0] hi
	);
		logic signed [11:0] r;
		r = v;
		if (r < $signed({2'b00, lo})) begin
			r = {2'b00, lo};
		end
		if (r > $signed({2'b00, hi})) begin
			r = {2'b00, hi};
		end
		return r[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic signed [11:0] widen(input logic signed [2:0] d);
		return {{9{d[2]}}, d};
	endfunction

	// handshake: input register refills while the result register waits
	assign s2_free      = !valid_s2 || result.ready;
	assign advance      = valid_s1 && s2_free;
	assign poll.ready   = !valid_s1 || advance;
	assign result.valid = valid_s2;
	assign result.item  = res_s2;
	assign cfg.ready    = 1'b1;

	// stamp reduced to the tracking width, zero extended when wider
	assign now_wide = 64'(item_s1.now_ms);
	assign now      = now_wide[TW-1:0];

	// per-button hold tracking, all six in parallel
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			held[i]      = now - press_q[i];
			since[i]     = now - last_q[i];
			press_nxt[i] = press_q[i];
			last_nxt[i]  = last_q[i];
			first_nxt[i] = first_q[i];
			rep_nxt[i]   = rep_q[i];
			steps[i]     = 2'd0;
			if (item_s1.button_levels[i] && !prior_q[i]) begin
				// press edge: start timing, no step yet
				press_nxt[i] = now;
				last_nxt[i]  = '0;
				first_nxt[i] = 1'b0;
				rep_nxt[i]   = 1'b0;
			end else if (item_s1.button_levels[i] && prior_q[i]) begin
				if (held[i] >= TW'(dead_q)) begin
					if (!first_q[i]) begin
						steps[i]     = 2'd1;
						first_nxt[i] = 1'b1;
					end
					if (!rep_q[i] && held[i] >= TW'(rstart_q)) begin
						// extra step, auto repeat begins
						steps[i]    = steps[i] + 2'd1;
						rep_nxt[i]  = 1'b1;
						last_nxt[i] = now;
					end else if (rep_q[i] && since[i] >= TW'(rint_q)) begin
						steps[i]    = steps[i] + 2'd1;
						last_nxt[i] = now;
					end
				end
			end else if (!item_s1.button_levels[i] && prior_q[i]) begin
				// release edge: clear all timing of this button
				press_nxt[i] = '0;
				last_nxt[i]  = '0;
				first_nxt[i] = 1'b0;
				rep_nxt[i]   = 1'b0;
			end
		end
	end

	// even buttons raise, odd buttons lower
	always_comb begin
		for (int p = 0; p < NUM_VALUES; p++) begin
			if (item_s1.change_allowed) begin
				delta[p] = $signed({1'b0, steps[2*p]}) - $signed({1'b0, steps[2*p+1]});
			end else begin
				delta[p] = 3'sd0;
			end
		end
	end

	// load replaces the sums; clamp runs on both paths
	always_comb begin
		if (item_s1.action) begin
			sum1 = {2'b00, item_s1.load_temp_one};
			sum2 = {2'b00, item_s1.load_temp_two};
			sum3 = {2'b00, item_s1.load_hold_minutes};
		end else begin
			sum1 = $signed({2'b00, temp1_q}) + widen(delta[0]);
			sum2 = $signed({2'b00, temp2_q}) + widen(delta[1]);
			sum3 = $signed({2'b00, hold_q}) + widen(delta[2]);
		end
		temp1_nxt = clamp_val(sum1, '0, temp_hi_q);
		temp2_nxt = clamp_val(sum2, '0, temp_hi_q);
		hold_nxt  = clamp_val(sum3, hold_lo_q, hold_hi_q);
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			dead_q    <= DEAD_TIME_RESET;
			rstart_q  <= REPEAT_START_RESET;
			rint_q    <= REPEAT_INTERVAL_RESET;
			temp_hi_q <= TEMP_UPPER_RESET;
			hold_lo_q <= HOLD_LOWER_RESET;
			hold_hi_q <= HOLD_UPPER_RESET;
			prior_q   <= '0;
			first_q   <= '0;
			rep_q     <= '0;
			temp1_q   <= '0;
			temp2_q   <= '0;
			hold_q    <= HOLD_VALUE_RESET;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				press_q[i] <= '0;
				last_q[i]  <= '0;
			end
		end else begin
			if (poll.valid && poll.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end

			if (cfg.valid) begin
				unique case (cfg.index)
					REG_DEAD_TIME:       dead_q    <= cfg.data;
					REG_REPEAT_START:    rstart_q  <= cfg.data;
					REG_REPEAT_INTERVAL: rint_q    <= cfg.data;
					REG_TEMP_UPPER:      temp_hi_q <= cfg.data[VALUE_WIDTH-1:0];
					REG_HOLD_LOWER:      hold_lo_q <= cfg.data[VALUE_WIDTH-1:0];
					REG_HOLD_UPPER:      hold_hi_q <= cfg.data[VALUE_WIDTH-1:0];
					default: begin
					end
				endcase
			end

			if (advance) begin
				temp1_q <= temp1_nxt;
				temp2_q <= temp2_nxt;
				hold_q  <= hold_nxt;
				// a load leaves the button state untouched
				if (!item_s1.action) begin
					prior_q <= item_s1.button_levels;
					first_q <= first_nxt;
					rep_q   <= rep_nxt;
					for (int i = 0; i < NUM_BUTTONS; i++) begin
						press_q[i] <= press_nxt[i];
						last_q[i]  <= last_nxt[i];
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			item_s1 <= poll.item;
		end
		if (advance) begin
			res_s2.target_temp_one    <= temp1_nxt;
			res_s2.target_temp_two    <= temp2_nxt;
			res_s2.hold_minutes_value <= hold_nxt;
			res_s2.repeat_mask        <= item_s1.action ? rep_q : rep_nxt;
		end
	end

endmodule
